// File: hdl/kti_pkg.sv
// ----------------------------------------------------------------------------
// kti_pkg
// Shared codes and controller/datapath interface types for the keyframe
// track interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package kti_pkg;

  // stored key kinds
  localparam logic [2:0] KIND_FLAG   = 3'd0;
  localparam logic [2:0] KIND_INT    = 3'd1;
  localparam logic [2:0] KIND_SCALAR = 3'd2;
  localparam logic [2:0] KIND_TRIPLE = 3'd3;
  localparam logic [2:0] KIND_QUAD   = 3'd4;
  localparam logic [2:0] KIND_NONE   = 3'd5;

  // input beat opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // register indexes
  localparam logic REG_VALUE_KIND = 1'b0;
  localparam logic REG_KEY_COUNT  = 1'b1;

  localparam int FRAC_BITS = 16;

  typedef struct packed {
    logic load;
    logic rd_lower;
    logic rd_upper;
    logic search_step;
    logic cap_lower;
    logic cap_upper;
    logic frac_init;
    logic div_step;
    logic mul;
    logic acc;
    logic fin_ok;
    logic fin_fail;
  } kti_cmd_t;

  typedef struct packed {
    logic pre_fail;
    logic len_zero;
    logic lo_zero;
    logic need_div;
    logic div_last;
    logic no_lanes;
    logic lane_last;
  } kti_status_t;

endpackage

`default_nettype wire

// File: hdl/kti_ram.sv
// ----------------------------------------------------------------------------
// kti_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/kti_dp.sv
// ----------------------------------------------------------------------------
// kti_dp
// Datapath: key tables, bisection search registers, serial fraction
// divider, per-lane blend multiplier and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module kti_dp
  import kti_pkg::*;
#(
  parameter int MAX_KEYS = 256,
  parameter int LANES    = 4
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire kti_cmd_t                cmd,
  output kti_status_t                  status,
  input  wire logic                    wr_en,
  input  wire logic [7:0]              wr_index,
  input  wire logic [31:0]             wr_time,
  input  wire logic [3:0][31:0]        wr_values,
  input  wire logic [31:0]             query_time,
  input  wire logic [2:0]              requested_kind,
  input  wire logic [2:0]              value_kind,
  input  wire logic [8:0]              key_count,
  output logic                         done,
  output logic                         ok,
  output logic [7:0]                   lower_key,
  output logic [7:0]                   upper_key,
  output logic [16:0]                  fraction,
  output logic [3:0][31:0]             results
);

  localparam int AW = $clog2(MAX_KEYS);
  localparam int NW = $clog2(MAX_KEYS + 1);
  localparam int VW = 32 * LANES;

  logic [NW-1:0] n, lo, len, half;
  logic [AW-1:0] mid, lower, upper, raddr, waddr;
  logic          has_upper, wr_ok;
  logic [31:0]   t_rd;
  logic [VW-1:0] v_rd, v_wr;
  logic [3:0][31:0] vl;

  logic signed [31:0] q, t0, t1;
  logic [2:0]         req_kind;
  logic [3:0][31:0]   v0, v1, res;
  logic [16:0]        frac;
  logic [33:0]        rem, r2;
  logic [3:0]         div_cnt;
  logic               need_div;
  logic [1:0]         lane;
  logic [2:0]         nl;
  logic signed [50:0] prod, total, rounded;
  logic signed [32:0] span, q_off, diff;
  logic               ge;

  always_comb begin
    if (32'(key_count) > MAX_KEYS) begin
      n = NW'(MAX_KEYS);
    end else begin
      n = NW'(key_count);
    end
  end

  assign half      = len >> 1;
  assign mid       = AW'(lo + half);
  assign lower     = AW'(lo - NW'(1));
  assign has_upper = lo < n;
  assign upper     = has_upper ? AW'(lo) : lower;

  always_comb begin
    if (cmd.rd_lower) begin
      raddr = lower;
    end else if (cmd.rd_upper) begin
      raddr = upper;
    end else begin
      raddr = mid;
    end
  end

  assign wr_ok = wr_en && (32'(wr_index) < MAX_KEYS);
  assign waddr = AW'(wr_index);

  genvar g;
  generate
    for (g = 0; g < 4; g++) begin : g_lane
      if (g < LANES) begin : g_on
        assign vl[g] = v_rd[32*g +: 32];
        assign v_wr[32*g +: 32] = wr_values[g];
      end else begin : g_off
        assign vl[g] = '0;
      end
    end
  endgenerate

  kti_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_time_ram (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (waddr),
    .wdata (wr_time),
    .raddr (raddr),
    .rdata (t_rd)
  );

  kti_ram #(.WIDTH(VW), .DEPTH(MAX_KEYS)) u_value_ram (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (waddr),
    .wdata (v_wr),
    .raddr (raddr),
    .rdata (v_rd)
  );

  always_comb begin
    case (value_kind)
      KIND_FLAG:   nl = 3'd0;
      KIND_INT:    nl = 3'd1;
      KIND_SCALAR: nl = 3'd1;
      KIND_TRIPLE: nl = 3'd3;
      default:     nl = 3'd4;
    endcase
  end

  assign span  = {t1[31], t1} - {t0[31], t0};
  assign q_off = {q[31], q} - {t0[31], t0};
  assign r2    = {rem[32:0], 1'b0};
  assign ge    = r2 >= {1'b0, span};
  assign diff  = {v1[lane][31], v1[lane]} - {v0[lane][31], v0[lane]};

  // v0 * 2^16 plus the weighted difference, then truncate or round
  assign total = {{3{v0[lane][31]}}, v0[lane], 16'b0} + prod;
  always_comb begin
    if (value_kind == KIND_INT) begin
      rounded = total + (total[50] ? 51'sd65535 : 51'sd0);
    end else begin
      rounded = total + 51'sd32768;
    end
  end

  assign status.pre_fail  = (req_kind != value_kind) || (value_kind > KIND_QUAD) ||
                            (n == '0);
  assign status.len_zero  = len == '0;
  assign status.lo_zero   = lo == '0;
  assign status.need_div  = need_div;
  assign status.div_last  = div_cnt == 4'd15;
  assign status.no_lanes  = nl == 3'd0;
  assign status.lane_last = {1'b0, lane} == (nl - 3'd1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q        <= query_time;
      req_kind <= requested_kind;
      lo       <= '0;
      len      <= n;
      lane     <= '0;
      res      <= '0;
      need_div <= 1'b0;
    end
    if (cmd.search_step) begin
      if ($signed(t_rd) <= q) begin
        lo  <= lo + half + NW'(1);
        len <= len - half - NW'(1);
      end else begin
        len <= half;
      end
    end
    if (cmd.cap_lower) begin
      t0 <= t_rd;
      v0 <= vl;
      if (value_kind == KIND_FLAG) begin
        res[0] <= {31'b0, |vl[0][7:0]};
      end
    end
    if (cmd.cap_upper) begin
      t1 <= t_rd;
      v1 <= vl;
    end
    if (cmd.frac_init) begin
      div_cnt  <= '0;
      need_div <= 1'b0;
      rem      <= {1'b0, q_off};
      if (!has_upper || span <= 0) begin
        frac <= '0;
      end else if (q_off >= span) begin
        frac <= 17'h10000;
      end else begin
        frac     <= '0;
        need_div <= 1'b1;
      end
    end
    if (cmd.div_step) begin
      rem     <= ge ? r2 - {1'b0, span} : r2;
      frac    <= {frac[15:0], ge};
      div_cnt <= div_cnt + 4'd1;
      if (div_cnt == 4'd15) begin
        need_div <= 1'b0;
      end
    end
    if (cmd.mul) begin
      prod <= diff * $signed({1'b0, frac});
    end
    if (cmd.acc) begin
      res[lane] <= rounded[47:16];
      lane      <= lane + 2'd1;
    end
    if (cmd.fin_ok) begin
      lower_key <= 8'(lower);
      upper_key <= 8'(upper);
      fraction  <= frac;
      results   <= res;
    end else if (cmd.fin_fail) begin
      lower_key <= '0;
      upper_key <= '0;
      fraction  <= '0;
      results   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      ok   <= 1'b0;
    end else begin
      done <= cmd.fin_ok | cmd.fin_fail;
      if (cmd.fin_ok | cmd.fin_fail) begin
        ok <= cmd.fin_ok;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/kti_ctrl.sv
// ----------------------------------------------------------------------------
// kti_ctrl
// Controller: sequences search, key fetch, fraction division and lane
// blending for one query.
// ----------------------------------------------------------------------------
`default_nettype none

module kti_ctrl
  import kti_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        query,
  input  wire kti_status_t status,
  output kti_cmd_t         cmd,
  output logic             busy
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_CHECK    = 13'b0000000000010,
    S_SRD      = 13'b0000000000100,
    S_SCMP     = 13'b0000000001000,
    S_LORD     = 13'b0000000010000,
    S_HIRD     = 13'b0000000100000,
    S_HICAP    = 13'b0000001000000,
    S_FRAC     = 13'b0000010000000,
    S_DIV      = 13'b0000100000000,
    S_MUL      = 13'b0001000000000,
    S_ACC      = 13'b0010000000000,
    S_FIN_OK   = 13'b0100000000000,
    S_FIN_FAIL = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (query) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = status.pre_fail ? S_FIN_FAIL : S_SRD;
      end
      S_SRD: begin
        // ram address is mid by default
        state_next = status.len_zero ? S_LORD : S_SCMP;
      end
      S_SCMP: begin
        cmd.search_step = 1'b1;
        state_next      = S_SRD;
      end
      S_LORD: begin
        if (status.lo_zero) begin
          state_next = S_FIN_FAIL;
        end else begin
          cmd.rd_lower = 1'b1;
          state_next   = S_HIRD;
        end
      end
      S_HIRD: begin
        cmd.cap_lower = 1'b1;
        cmd.rd_upper  = 1'b1;
        state_next    = S_HICAP;
      end
      S_HICAP: begin
        cmd.cap_upper = 1'b1;
        state_next    = S_FRAC;
      end
      S_FRAC: begin
        cmd.frac_init = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (status.need_div && !status.div_last) begin
          cmd.div_step = 1'b1;
        end else begin
          cmd.div_step = status.need_div;
          state_next   = status.no_lanes ? S_FIN_OK : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = status.lane_last ? S_FIN_OK : S_MUL;
      end
      S_FIN_OK: begin
        cmd.fin_ok = 1'b1;
        state_next = S_IDLE;
      end
      S_FIN_FAIL: begin
        cmd.fin_fail = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/keyframe_track_interpolator.sv
// ----------------------------------------------------------------------------
// keyframe_track_interpolator
// Piecewise-linear keyframe track: key table writes and interpolating queries.
//
//   channel   signals                                   beat taken when
//   input     start, busy, kind .. requested_kind       start && !busy
//   result    done, ok .. result_w                      done (one cycle)
//   config    psel penable pwrite paddr pwdata prdata   psel&penable&pwrite
//
// A key write leaves busy low. A query holds busy: it fails on a bad kind
// or count or when no key lies at or before the query time; else it runs
// the bisection steps (one ram read and one compare each, at most 9 steps),
// the serial fraction divider when needed and a multiply and accumulate per
// blended lane. done is high in the first cycle that busy is low. Reset
// clears config registers, done, ok and the controller only; key tables hold
// garbage until written. The receiver cannot stall, so a result is never held.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_track_interpolator
  import kti_pkg::*;
#(
  parameter int MAX_KEYS = 256,
  parameter int LANES    = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        kind,
  input  wire logic [7:0]  key_index,
  input  wire logic [31:0] key_time,
  input  wire logic [31:0] value_x,
  input  wire logic [31:0] value_y,
  input  wire logic [31:0] value_z,
  input  wire logic [31:0] value_w,
  input  wire logic [31:0] query_time,
  input  wire logic [2:0]  requested_kind,
  output logic             done,
  output logic             ok,
  output logic [7:0]       lower_key,
  output logic [7:0]       upper_key,
  output logic [16:0]      fraction,
  output logic [31:0]      result_x,
  output logic [31:0]      result_y,
  output logic [31:0]      result_z,
  output logic [31:0]      result_w
);

  logic [2:0]       value_kind;
  logic [8:0]       key_count;
  logic             cfg_wr, accept;
  kti_cmd_t         cmd;
  kti_status_t      status;
  logic [3:0][31:0] results;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      value_kind <= KIND_NONE;
      key_count  <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_VALUE_KIND) begin
        value_kind <= pwdata[2:0];
      end else begin
        key_count <= pwdata[8:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_KEY_COUNT) begin
      prdata = {23'b0, key_count};
    end else begin
      prdata = {29'b0, value_kind};
    end
  end

  kti_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .query  (accept && kind == OP_QUERY),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  kti_dp #(.MAX_KEYS(MAX_KEYS), .LANES(LANES)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .wr_en          (accept && kind == OP_WRITE),
    .wr_index       (key_index),
    .wr_time        (key_time),
    .wr_values      ({value_w, value_z, value_y, value_x}),
    .query_time     (query_time),
    .requested_kind (requested_kind),
    .value_kind     (value_kind),
    .key_count      (key_count),
    .done           (done),
    .ok             (ok),
    .lower_key      (lower_key),
    .upper_key      (upper_key),
    .fraction       (fraction),
    .results        (results)
  );

  assign result_x = results[0];
  assign result_y = results[1];
  assign result_z = results[2];
  assign result_w = results[3];

  // a result beat always closes a query that held busy
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without a query in flight");

  a_upper_follows_lower: assert property (@(posedge clk) disable iff (rst)
    (done && ok) |-> (upper_key == lower_key || upper_key == lower_key + 8'd1))
    else $error("upper key not adjacent to lower key");

  a_fail_clears: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (fraction == '0 && result_x == '0 && lower_key == '0))
    else $error("failed query left payload nonzero");

  a_no_start_while_busy: assert property (@(posedge clk) disable iff (rst)
    (busy && !$past(busy)) |-> !done)
    else $error("result beat overlapped query start");

endmodule

`default_nettype wire
